/* src/bdae_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdae_pkg
// Shared types, constants and the double-dabble step for the decimal emitter.
// ----------------------------------------------------------------------------
package bdae_pkg;

  localparam int unsigned BIN_W          = 16;
  localparam int unsigned DIGITS         = 5;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned BCD_W          = DIGITS * DIGIT_W;
  localparam int unsigned STAGES         = 4;
  localparam int unsigned BITS_PER_STAGE = BIN_W / STAGES;
  localparam int unsigned CHAR_W         = 6;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;
  localparam logic [DIGIT_W-1:0] MAX_DIGIT  = 4'd9;

  // Working word of the conversion: BCD accumulator above, binary bits left
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [BIN_W-1:0] bin;
  } dd_t;

  // Number of characters still to send, 0 to DIGITS
  typedef logic [2:0] count_t;

  // One shift-and-add-3 iteration
  function automatic dd_t dabble_step(dd_t x);
    dd_t y;
    y = x;
    for (int i = 0; i < DIGITS; i++) begin
      if (y.bcd[DIGIT_W*i +: DIGIT_W] >= ADJ_LIMIT) begin
        y.bcd[DIGIT_W*i +: DIGIT_W] = y.bcd[DIGIT_W*i +: DIGIT_W] + ADJ_ADD;
      end
    end
    y = dd_t'({y.bcd, y.bin} << 1);
    return y;
  endfunction

endpackage

/* src/bdae_dabble_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdae_dabble_stage
// One pipeline stage of the binary to BCD conversion, four bits per stage.
// ----------------------------------------------------------------------------
module bdae_dabble_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  bdae_pkg::dd_t  data_i,
  output logic           valid_o,
  output bdae_pkg::dd_t  data_o
);

  logic          valid_q;
  bdae_pkg::dd_t data_d, data_q;

  always_comb begin
    data_d = data_i;
    for (int j = 0; j < bdae_pkg::BITS_PER_STAGE; j++) begin
      data_d = bdae_pkg::dabble_step(data_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // payload moves only with a valid transaction
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* src/bdae_serialiser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdae_serialiser
// Drops leading zeros and sends the digits as ASCII, one per cycle.
// ----------------------------------------------------------------------------
module bdae_serialiser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [bdae_pkg::BCD_W-1:0]         bcd_i,
  output logic                               ready_o,
  output logic                               strobe_o,
  output logic [bdae_pkg::CHAR_W-1:0]        digit_char_o,
  output logic                               last_digit_o
);

  localparam int unsigned DW = bdae_pkg::DIGIT_W;
  localparam int unsigned BW = bdae_pkg::BCD_W;

  logic [BW-1:0]    digs_d, digs_q;
  bdae_pkg::count_t cnt_d, cnt_q;
  bdae_pkg::count_t n_load;
  logic [BW-1:0]    aligned;
  logic             load;
  logic [DW-1:0]    head;

  // significant digit count, zero keeps one digit
  always_comb begin
    n_load = bdae_pkg::count_t'(1);
    for (int i = 1; i < bdae_pkg::DIGITS; i++) begin
      if (bcd_i[DW*i +: DW] != '0) begin
        n_load = bdae_pkg::count_t'(i + 1);
      end
    end
  end

  // left-align so the leading significant digit sits at the top
  always_comb begin
    case (n_load)
      3'd5:    aligned = bcd_i;
      3'd4:    aligned = bcd_i << DW;
      3'd3:    aligned = bcd_i << (2 * DW);
      3'd2:    aligned = bcd_i << (3 * DW);
      default: aligned = bcd_i << (4 * DW);
    endcase
  end

  assign ready_o = (cnt_q <= bdae_pkg::count_t'(1));
  assign load    = valid_i && ready_o;

  always_comb begin
    digs_d = digs_q;
    cnt_d  = cnt_q;
    if (load) begin
      digs_d = aligned;
      cnt_d  = n_load;
    end else if (cnt_q != '0) begin
      digs_d = digs_q << DW;
      cnt_d  = cnt_q - bdae_pkg::count_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digs_q <= digs_d;
  end

  assign head         = digs_q[BW-1 -: DW];
  assign strobe_o     = (cnt_q != '0);
  assign last_digit_o = (cnt_q == bdae_pkg::count_t'(1));
  assign digit_char_o = bdae_pkg::ASCII_ZERO + bdae_pkg::CHAR_W'(head);

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> head <= bdae_pkg::MAX_DIGIT)
    else $error("emitted digit out of decimal range");

  a_load_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> strobe_o)
    else $error("loaded transaction not emitted");

  a_no_lead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && n_load != bdae_pkg::count_t'(1) |=> head != '0)
    else $error("leading zero emitted");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bdae_pkg::count_t'(bdae_pkg::DIGITS))
    else $error("digit count overflow");

endmodule

/* src/binary_to_decimal_ascii_emitter.sv */
`timescale 1ns / 1ps
// Path: a start transaction passes the dabble stages and then the serialiser's
//   digit register before its first character is on the ports.
// Throughput: one character per cycle; a number sends 1 to 5 characters, one
//   per significant digit, through the single-character result port.
// busy rises only when the conversion pipeline is full; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the pipeline and the serialiser.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_emitter
// Converts a 16-bit unsigned number to ASCII decimal text, leading zeros
// suppressed, last character flagged.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_emitter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [bdae_pkg::BIN_W-1:0]  value_i,
  output logic                        strobe_o,
  output logic [bdae_pkg::CHAR_W-1:0] digit_char_o,
  output logic                        last_digit_o
);

  localparam int unsigned NS = bdae_pkg::STAGES;

  // Four double-dabble stages of four bits each, valid bits alongside.
  logic              st_valid [NS+1];
  bdae_pkg::dd_t     st_data  [NS+1];
  logic              adv      [NS];
  logic              ser_ready;

  // Stage input: BCD accumulator cleared, binary word loaded.
  assign st_valid[0]    = start && !busy;
  assign st_data[0].bcd = '0;
  assign st_data[0].bin = value_i;

  // Stall chain: a stage moves when empty or when the one after it moves.
  always_comb begin
    adv[NS-1] = !st_valid[NS] || ser_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !st_valid[k+1] || adv[k+1];
    end
  end

  // busy when the first stage holds a transaction that cannot move on
  assign busy = !adv[0];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    bdae_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv[g]),
      .valid_i (st_valid[g]),
      .data_i  (st_data[g]),
      .valid_o (st_valid[g+1]),
      .data_o  (st_data[g+1])
    );
  end

  // Output side: takes a finished BCD word while sending the last digit of
  // the previous one, so numbers go out back to back.
  bdae_serialiser u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (st_valid[NS]),
    .bcd_i        (st_data[NS].bcd),
    .ready_o      (ser_ready),
    .strobe_o     (strobe_o),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

  a_busy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> st_valid[1] && st_valid[NS])
    else $error("busy with an empty pipeline");

  a_last_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_digit_o |-> strobe_o)
    else $error("last flag without a character");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_valid[NS] && !ser_ready |=> st_valid[NS] && $stable(st_data[NS].bcd))
    else $error("finished word lost while the serialiser was full");

endmodule
